// ----- hdl/adq_pkg.sv -----
// Shared types, codes and defaults for the array double-ended queue.
package adq_pkg;

    // Default number of slots in the element store.
    localparam int DEPTH_DEF = 128;

    // Widths of the transaction fields.
    localparam int CMD_W  = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 8;

    // Packed stream words, padded to whole bytes.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // Commands carried by an input transaction.
    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_REAR  = 2'd1,
        CMD_REM_FRONT = 2'd2,
        CMD_REM_REAR  = 2'd3
    } t_cmd;

    // Status codes returned with each result.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_REAR  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_FRONT = 2'd3;

    // Value returned by a removal from an empty deque.
    localparam logic [VAL_W-1:0] EMPTY_READ = '1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// ----- hdl/adq_ram.sv -----
// Generic single-port RAM with a registered read.
module adq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read; read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/adq_ctrl.sv -----
// Controller state machine sequencing one transaction at a time.
module adq_ctrl
    import adq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/adq_dp.sv -----
// Datapath: indices, capacity register, element store and output register.
module adq_dp
    import adq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic                i_cfg_valid,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Latched transaction.
    t_cmd                     r_cmd;
    logic signed [VAL_W-1:0]  r_value;

    // Deque state.
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic          r_empty, n_empty;
    logic [CW-1:0] r_cap;

    // Result under construction.
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_use_rd, n_use_rd;

    // Output register.
    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_out_status;
    logic signed [VAL_W-1:0] r_out_value;

    // Store access.
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_addr;
    logic [VAL_W-1:0]  mem_rdata;
    logic [CW-1:0]     eff_cap;
    logic [CW-1:0]     tail_inc;

    // Capture the input transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= t_cmd'(i_s_tdata[CMD_W-1:0]);
            r_value <= i_s_tdata[CMD_W +: VAL_W];
        end
    end

    // Capacity register; writes are taken whenever offered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= DEPTH_C;
        end else if (i_cfg_valid) begin
            r_cap <= CW'(i_cfg_data);
        end
    end

    // Usable capacity: zero acts as one, anything above the store size as the store size.
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CW'(1);
        end else if (r_cap > DEPTH_C) begin
            eff_cap = DEPTH_C;
        end else begin
            eff_cap = r_cap;
        end
    end

    assign tail_inc = CW'(r_tail) + CW'(1);

    // Command execution: index updates, store access and status.
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_status = ST_OK;
        n_use_rd = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = '0;
        case (r_cmd)
            CMD_INS_FRONT, CMD_INS_REAR: begin
                if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    mem_we  = 1'b1;
                end else if (r_cmd == CMD_INS_FRONT) begin
                    if (r_head != '0) begin
                        n_head   = r_head - AW'(1);
                        mem_we   = 1'b1;
                        mem_addr = r_head - AW'(1);
                    end else begin
                        n_status = ST_NO_FRONT;
                    end
                end else begin
                    if (tail_inc < eff_cap) begin
                        n_tail   = tail_inc[AW-1:0];
                        mem_we   = 1'b1;
                        mem_addr = tail_inc[AW-1:0];
                    end else begin
                        n_status = ST_NO_REAR;
                    end
                end
            end
            CMD_REM_FRONT, CMD_REM_REAR: begin
                if (r_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_use_rd = 1'b1;
                    mem_re   = 1'b1;
                    mem_addr = (r_cmd == CMD_REM_FRONT) ? r_head : r_tail;
                    if (r_head >= r_tail) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b1;
                    end else if (r_cmd == CMD_REM_FRONT) begin
                        n_head = r_head + AW'(1);
                    end else begin
                        n_tail = r_tail - AW'(1);
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Deque state registers, updated when a command executes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    // Result held until the store read data arrives.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_use_rd <= n_use_rd;
        end
    end

    adq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we && i_cmd.exec),
        .i_re    (mem_re && i_cmd.exec),
        .i_addr  (mem_addr),
        .i_wdata (r_value),
        .o_rdata (mem_rdata)
    );

    // Output register: loads on emit, drains when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            if (r_use_rd) begin
                r_out_value <= mem_rdata;
            end else if (r_status == ST_EMPTY) begin
                r_out_value <= EMPTY_READ;
            end else begin
                r_out_value <= '0;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = {{(M_DATA_W - STAT_W - VAL_W){1'b0}}, r_out_value, r_out_status};

endmodule

// ----- hdl/array_double_ended_queue.sv -----
// Top level of the array double-ended queue.
//
// Double-ended queue over a linear, non-wrapping array of DEPTH 32-bit slots.
// Input transactions arrive on the s_ stream: tdata carries the command in
// bits [1:0] (insert front, insert rear, remove front, remove rear) and the
// value in bits [33:2]. Each input transaction yields exactly one result on
// the m_ stream: tdata carries the status in bits [1:0] and the read value in
// bits [33:2]. The cfg channel writes the capacity register (8 bits); it is
// always ready and should only be written while the block is idle.
// After acceptance, the execute step updates the indices and accesses the
// element store, whose registered read returns at the same edge, and the
// result step then loads the result into the output register. The block
// takes one item at a time through the three controller steps (idle,
// execute, result). The input is accepted only in the idle state, so a new
// item cannot enter before the previous result is loaded, but can enter while it waits.
// If the receiver stalls, the finished result waits in the output register
// and the next item holds in its result step until the register frees.
// Reset (synchronous, active low) empties the deque, sets both indices to 0
// and the capacity to DEPTH; the store contents are not cleared.
module array_double_ended_queue
    import adq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // command [1:0], value [33:2]
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // status [1:0], read_value [33:2]
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data   // capacity
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    adq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    adq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // Only one transaction is in flight: acceptance closes the input for the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while a transaction is in flight");

    // An empty removal always reads back minus one.
    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] == ST_EMPTY) |-> (o_m_tdata[33:2] == EMPTY_READ))
        else $error("empty removal with a read value other than minus one");

    // A failed insert reads back zero.
    a_fail_insert_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[1:0] == ST_NO_REAR || o_m_tdata[1:0] == ST_NO_FRONT))
        |-> (o_m_tdata[33:2] == '0))
        else $error("failed insert with a nonzero read value");

    // Padding bits of the result word stay clear.
    a_pad_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[39:34] == '0))
        else $error("result padding bits set");

endmodule

// ----- tb/array_double_ended_queue_tb.sv -----
// Self-checking testbench for the array double-ended queue: directed and random traffic.
module array_double_ended_queue_tb;
    import adq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Traffic shapes used by the random part.
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_EVEN   = 2;

    // Cycles allowed for the last result to clear the pipeline.
    localparam int SETTLE_CYCLES = 8;
    // Cycles without any transaction before the run is abandoned.
    localparam int STALL_LIMIT   = 3000;
    // Length of the single long receiver hold-off.
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        t_cmd             cmd;
        logic [VAL_W-1:0] value;
    } t_deque_item;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
    } t_deque_result;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata   = '0;   // command [1:0], value [33:2]
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;          // status [1:0], read_value [33:2]
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data  = '0;   // capacity

    // Items waiting to be offered, and results still owed by the block.
    t_deque_item   item_q[$];
    t_deque_result result_q[$];

    // Shadow copy of the deque and its capacity register.
    logic [VAL_W-1:0] shadow_slots[DEPTH_DEF];
    int               shadow_head  = 0;
    int               shadow_tail  = 0;
    bit               shadow_empty = 1'b1;
    logic [CFG_W-1:0] capacity_reg = CFG_W'(DEPTH_DEF);

    int n_err     = 0;
    int n_results = 0;

    // Sender and receiver pacing.
    int  burst_left = 1;
    int  gap_left   = 0;
    int  hold_left  = 0;
    bit  held_once  = 1'b0;
    int  rx_mode    = 0;
    int  rx_left    = 0;
    int  rx_phase   = 0;
    int  quiet_cycles = 0;

    array_double_ended_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Apply one command to the shadow deque and return the result it should give.
    function automatic t_deque_result deque_apply(input t_cmd cmd, input logic [VAL_W-1:0] val);
        t_deque_result r;
        int            cap;
        cap = (capacity_reg == 0) ? 1 : (int'(capacity_reg) > DEPTH_DEF) ? DEPTH_DEF
                                                                        : int'(capacity_reg);
        r.status = ST_OK;
        r.value  = '0;
        case (cmd)
            CMD_INS_FRONT, CMD_INS_REAR: begin
                if (shadow_empty) begin
                    shadow_head     = 0;
                    shadow_tail     = 0;
                    shadow_empty    = 1'b0;
                    shadow_slots[0] = val;
                end else if (cmd == CMD_INS_FRONT) begin
                    if (shadow_head > 0) begin
                        shadow_head--;
                        shadow_slots[shadow_head] = val;
                    end else begin
                        r.status = ST_NO_FRONT;
                    end
                end else if (shadow_tail + 1 < cap) begin
                    shadow_tail++;
                    shadow_slots[shadow_tail] = val;
                end else begin
                    r.status = ST_NO_REAR;
                end
            end
            default: begin
                if (shadow_empty) begin
                    r.status = ST_EMPTY;
                    r.value  = EMPTY_READ;
                end else begin
                    r.value = (cmd == CMD_REM_FRONT) ? shadow_slots[shadow_head]
                                                     : shadow_slots[shadow_tail];
                    // Taking the last element leaves both indices at zero.
                    if (shadow_head >= shadow_tail) begin
                        shadow_head  = 0;
                        shadow_tail  = 0;
                        shadow_empty = 1'b1;
                    end else if (cmd == CMD_REM_FRONT) begin
                        shadow_head++;
                    end else begin
                        shadow_tail--;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic add_item(input t_cmd cmd, input logic [VAL_W-1:0] val);
        t_deque_item it;
        it.cmd   = cmd;
        it.value = val;
        item_q.push_back(it);
    endtask

    // Wait until every item has gone in and every result has come out.
    task automatic wait_idle();
        while (item_q.size() != 0 || result_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        capacity_reg = cap;
    endtask

    // Sender: records each accepted transaction and offers the next item in bursts.
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            result_q.push_back(deque_apply(item_q[0].cmd, item_q[0].value));
            item_q.delete(0);
        end
        if (!(i_s_tvalid && !o_s_tready)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (item_q.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {{(S_DATA_W - CMD_W - VAL_W){1'b0}}, item_q[0].value,
                               item_q[0].cmd};
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: changes its stall pattern now and then, with one long hold-off.
    always @(posedge i_clk) begin
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (!held_once && n_results >= 300 && item_q.size() > 20) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 120);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= ($urandom_range(0, 1) == 1);
                2:       i_m_tready <= (rx_phase % 3 == 0);
                default: i_m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Checker: each result transaction against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_deque_result want;
        if (o_m_tvalid && i_m_tready) begin
            n_results++;
            if (result_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result, expected none, actual status %0d value %h",
                         $time, o_m_tdata[1:0], o_m_tdata[33:2]);
            end else begin
                want = result_q.pop_front();
                if (o_m_tdata[1:0] !== want.status) begin
                    n_err++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_m_tdata[1:0]);
                end
                if (o_m_tdata[33:2] !== want.value) begin
                    n_err++;
                    $display("%0t: read value mismatch, expected %h, actual %h",
                             $time, want.value, o_m_tdata[33:2]);
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no transaction anywhere.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus: directed checks first, then random phases at several capacities.
    initial begin : stimulus
        int               plan_cap[10];
        int               plan_len[10];
        int               plan_grow[10];
        int               seg_left;
        int               seg_mix;
        int               roll;
        t_cmd             cmd;
        logic [VAL_W-1:0] val;

        plan_cap  = '{255, 128, 4, 1, 200, 9, 0, 64, 2, 128};
        plan_len  = '{140, 120, 80, 60, 120, 80, 50, 100, 60, 80};
        plan_grow = '{80, 70, 40, 30, 50, 40, 30, 50, 40, 20};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Removals from an empty deque, then both ends and the value extremes.
        add_item(CMD_REM_FRONT, 32'h1234_5678);
        add_item(CMD_REM_REAR,  32'h0);
        add_item(CMD_INS_FRONT, 32'h7FFF_FFFF);
        add_item(CMD_INS_FRONT, 32'h0BAD_F00D);   // head already at slot zero
        add_item(CMD_INS_REAR,  32'h8000_0000);
        add_item(CMD_INS_REAR,  32'h0000_0000);
        add_item(CMD_REM_FRONT, 32'hFFFF_FFFF);
        add_item(CMD_INS_FRONT, 32'hFFFF_FFFF);   // head back above zero
        add_item(CMD_REM_REAR,  32'h0);
        add_item(CMD_REM_REAR,  32'h0);
        add_item(CMD_REM_REAR,  32'h0);           // last element goes
        add_item(CMD_INS_REAR,  32'h5555_5555);
        add_item(CMD_REM_FRONT, 32'h0);
        add_item(CMD_INS_REAR,  32'hAAAA_AAAA);
        wait_idle();

        // Capacity lowered while the deque holds elements.
        write_capacity(8'd2);
        add_item(CMD_INS_REAR, 32'h0000_0001);
        add_item(CMD_INS_REAR, 32'h0000_0002);
        wait_idle();
        write_capacity(8'd1);
        add_item(CMD_INS_REAR,  32'h0000_0003);
        add_item(CMD_REM_REAR,  32'h0);
        add_item(CMD_REM_FRONT, 32'h0);
        wait_idle();

        // A zero capacity behaves as a capacity of one.
        write_capacity(8'd0);
        add_item(CMD_INS_REAR,  32'hDEAD_BEEF);
        add_item(CMD_INS_REAR,  32'h0000_0004);
        add_item(CMD_INS_FRONT, 32'h0000_0005);
        add_item(CMD_REM_REAR,  32'h0);
        add_item(CMD_REM_REAR,  32'h0);
        wait_idle();

        // Random phases; the deque carries its contents from one phase to the next.
        for (int p = 0; p < 10; p++) begin
            write_capacity(CFG_W'(plan_cap[p]));
            seg_left = 0;
            seg_mix  = MIX_EVEN;
            for (int k = 0; k < plan_len[p]; k++) begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(5, 30);
                    roll     = $urandom_range(0, 99);
                    seg_mix  = (roll < plan_grow[p]) ? MIX_GROW
                             : roll[0]               ? MIX_SHRINK : MIX_EVEN;
                end
                seg_left--;
                roll = $urandom_range(0, 99);
                case (seg_mix)
                    MIX_GROW:   cmd = (roll < 55) ? CMD_INS_REAR  : (roll < 70) ? CMD_INS_FRONT
                                    : (roll < 85) ? CMD_REM_FRONT : CMD_REM_REAR;
                    MIX_SHRINK: cmd = (roll < 15) ? CMD_INS_REAR  : (roll < 25) ? CMD_INS_FRONT
                                    : (roll < 65) ? CMD_REM_FRONT : CMD_REM_REAR;
                    default:    cmd = (roll < 25) ? CMD_INS_REAR  : (roll < 50) ? CMD_INS_FRONT
                                    : (roll < 75) ? CMD_REM_FRONT : CMD_REM_REAR;
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       val = 32'h0000_0000;
                        1:       val = 32'h7FFF_FFFF;
                        2:       val = 32'h8000_0000;
                        default: val = 32'hFFFF_FFFF;
                    endcase
                end else begin
                    val = $urandom();
                end
                add_item(cmd, val);
                // Once, the sender stops half-way until the block has answered everything.
                if (p == 4 && k == plan_len[p] / 2) begin
                    while (item_q.size() != 0 || result_q.size() != 0)
                        @(posedge i_clk);
                end
            end
            wait_idle();
        end

        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/adq_pkg.sv
hdl/adq_ram.sv
hdl/adq_ctrl.sv
hdl/adq_dp.sv
hdl/array_double_ended_queue.sv
tb/array_double_ended_queue_tb.sv
